// ----- rtl/i2c_master_bit_engine_core_defines.svh -----
// Assertion helpers for the checker file.
`ifndef I2C_MASTER_BIT_ENGINE_CORE_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define I2CMB_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("i2cmb check failed");

// next-cycle implication, off during reset
`define I2CMB_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("i2cmb check failed");

// next-cycle implication, live through reset
`define I2CMB_ASSERT_NEXT_RST(name, ante, cons) \
   name: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("i2cmb reset check failed");

`endif

// ----- rtl/i2cmb_pkg.sv -----
package i2cmb_pkg;

   // op codes
   localparam logic [3:0] OP_TICK    = 4'd0;
   localparam logic [3:0] OP_INIT    = 4'd1;
   localparam logic [3:0] OP_START   = 4'd2;
   localparam logic [3:0] OP_RESTART = 4'd3;
   localparam logic [3:0] OP_STOP    = 4'd4;
   localparam logic [3:0] OP_ACK     = 4'd5;
   localparam logic [3:0] OP_NAK     = 4'd6;
   localparam logic [3:0] OP_SEND    = 4'd7;
   localparam logic [3:0] OP_READ    = 4'd8;

   // no command running
   localparam logic [3:0] CMD_IDLE = OP_TICK;

   localparam logic [4:0] SEND_PHASES     = 5'd27;
   localparam logic [4:0] SEND_BIT_PHASES = 5'd24;
   localparam logic [4:0] SEND_RELEASE    = 5'd24;
   localparam logic [4:0] SEND_RAISE      = 5'd25;
   localparam logic [4:0] READ_PHASES     = 5'd16;
   localparam logic [4:0] SHORT2_PHASES   = 5'd2;
   localparam logic [4:0] SHORT4_PHASES   = 5'd4;

   localparam logic [7:0] TPP_RESET = 8'd1;

   // short sequences: bit p of a row = phase p; pin 1 means SDA, 0 means SCL
   localparam int SHORT_CMDS = 7;
   localparam logic [3:0] SHORT_PIN [SHORT_CMDS] = '{
      4'b0000, 4'b0001, 4'b0001, 4'b0101, 4'b1010, 4'b1001, 4'b1001
   };
   localparam logic [3:0] SHORT_VAL [SHORT_CMDS] = '{
      4'b0000, 4'b0011, 4'b0000, 4'b0011, 4'b1100, 4'b1010, 4'b1011
   };

   // front/back queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_TICK,
      KIND_CMD,
      KIND_NOP
   } item_kind_type;

   typedef struct packed {
      logic [3:0] op;
      logic [7:0] tx_byte;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       done_res;
      logic       ack_bit;
      logic [7:0] rx_byte;
      logic       rejected;
   } rsp_type;

   typedef struct packed {
      item_kind_type kind;
      logic [3:0]    op;
      logic [7:0]    tx_byte;
      logic          sda_in;
   } item_type;

   function automatic logic [4:0] seq_length(input logic [3:0] cmd);
      logic [4:0] len;
      case (cmd) inside
         OP_SEND:                                 len = SEND_PHASES;
         OP_READ:                                 len = READ_PHASES;
         OP_INIT, OP_START:                       len = SHORT2_PHASES;
         OP_RESTART, OP_STOP, OP_ACK, OP_NAK:     len = SHORT4_PHASES;
         default:                                 len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

// ----- rtl/i2cmb_front.sv -----
module i2cmb_front (
   input  logic               req_valid,
   output logic               req_stall,
   input  i2cmb_pkg::req_type req_data,
   input  logic               q_full,
   output logic               q_push,
   output i2cmb_pkg::item_type q_item
);
   import i2cmb_pkg::*;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_item.op      = req_data.op;
      q_item.tx_byte = req_data.tx_byte;
      q_item.sda_in  = req_data.sda_in;
      if (req_data.op == OP_TICK) begin
         q_item.kind = KIND_TICK;
      end else if (req_data.op <= OP_READ) begin
         q_item.kind = KIND_CMD;
      end else begin
         q_item.kind = KIND_NOP;   // unknown op: pass through, no effect
      end
   end

endmodule

// ----- rtl/i2cmb_queue.sv -----
module i2cmb_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  i2cmb_pkg::item_type push_item,
   output logic                full,
   input  logic                pop,
   output logic                valid,
   output i2cmb_pkg::item_type pop_item
);
   import i2cmb_pkg::*;

   item_type               store_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_item = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/i2cmb_back.sv -----
module i2cmb_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [7:0]          csr_wr_data,
   input  logic                q_valid,
   input  i2cmb_pkg::item_type q_item,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output i2cmb_pkg::rsp_type  rsp_data
);
   import i2cmb_pkg::*;

   logic [7:0] tpp_ff;
   logic [4:0] phase_ff, phase_in, phase_step;
   logic [3:0] cmd_ff, cmd_in;
   logic [7:0] tick_ff, tick_in;
   logic [1:0] sub_ff, sub_in;          // phase mod 3 during send
   logic [7:0] shift_out_ff, shift_out_in;
   logic [7:0] shift_in_ff, shift_in_in;
   logic       ack_ff, ack_in;
   logic       drv_scl_ff, drv_scl_in;
   logic       drv_sda_ff, drv_sda_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   logic       busy, load, run_phase, done, rej;
   logic [7:0] limit;
   logic [8:0] tick_sum;

   assign busy      = (cmd_ff != CMD_IDLE);
   assign load      = !rsp_valid_ff || !rsp_stall;
   assign q_pop     = q_valid && load;
   assign limit     = (tpp_ff == 8'd0) ? 8'd1 : tpp_ff;
   assign tick_sum  = {1'b0, tick_ff} + 9'd1;
   assign phase_step = phase_ff + 5'd1;

   always_comb begin
      phase_in     = phase_ff;
      cmd_in       = cmd_ff;
      tick_in      = tick_ff;
      sub_in       = sub_ff;
      shift_out_in = shift_out_ff;
      shift_in_in  = shift_in_ff;
      ack_in       = ack_ff;
      drv_scl_in   = drv_scl_ff;
      drv_sda_in   = drv_sda_ff;
      run_phase    = 1'b0;
      done         = 1'b0;
      rej          = 1'b0;

      if (q_pop) begin
         case (q_item.kind)
            KIND_TICK: begin
               if (busy) begin
                  if (tick_sum >= {1'b0, limit}) begin
                     tick_in = 8'd0;
                     if (phase_step >= seq_length(cmd_ff)) begin
                        cmd_in   = CMD_IDLE;
                        phase_in = 5'd0;
                        done     = 1'b1;
                     end else begin
                        phase_in  = phase_step;
                        sub_in    = (sub_ff == 2'd2) ? 2'd0 : sub_ff + 2'd1;
                        run_phase = 1'b1;
                     end
                  end else begin
                     tick_in = tick_sum[7:0];
                  end
               end
            end
            KIND_CMD: begin
               if (busy) begin
                  rej = 1'b1;
               end else begin
                  cmd_in   = q_item.op;
                  phase_in = 5'd0;
                  tick_in  = 8'd0;
                  sub_in   = 2'd0;
                  if (q_item.op == OP_SEND) begin
                     shift_out_in = q_item.tx_byte;
                  end
                  if (q_item.op == OP_READ) begin
                     shift_in_in = 8'd0;
                  end
                  run_phase = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      // pin action at the start of a phase
      if (run_phase) begin
         if (cmd_in == OP_SEND) begin
            if (phase_in < SEND_BIT_PHASES) begin
               case (sub_in)
                  2'd0:    drv_sda_in = shift_out_in[7];
                  2'd1:    drv_scl_in = 1'b1;
                  default: begin
                     drv_scl_in   = 1'b0;
                     shift_out_in = {shift_out_in[6:0], 1'b0};
                  end
               endcase
            end else if (phase_in == SEND_RELEASE) begin
               drv_sda_in = 1'b1;
            end else if (phase_in == SEND_RAISE) begin
               drv_scl_in = 1'b1;
            end else begin
               ack_in     = q_item.sda_in;
               drv_scl_in = 1'b0;
            end
         end else if (cmd_in == OP_READ) begin
            if (!phase_in[0]) begin
               drv_scl_in = 1'b1;
            end else begin
               shift_in_in = {shift_in_in[6:0], q_item.sda_in};
               drv_scl_in  = 1'b0;
            end
         end else if (cmd_in >= OP_INIT && cmd_in <= OP_NAK && phase_in < SHORT4_PHASES) begin
            if (SHORT_PIN[cmd_in[2:0]][phase_in[1:0]]) begin
               drv_sda_in = SHORT_VAL[cmd_in[2:0]][phase_in[1:0]];
            end else begin
               drv_scl_in = SHORT_VAL[cmd_in[2:0]][phase_in[1:0]];
            end
         end
      end

      rsp_data_in.scl_level = drv_scl_in;
      rsp_data_in.sda_level = drv_sda_in;
      rsp_data_in.busy_res  = (cmd_in != CMD_IDLE);
      rsp_data_in.done_res  = done;
      rsp_data_in.ack_bit   = ack_in;
      rsp_data_in.rx_byte   = shift_in_in;
      rsp_data_in.rejected  = rej;

      if (q_pop) begin
         rsp_valid_in = 1'b1;
      end else if (load) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tpp_ff       <= TPP_RESET;
         phase_ff     <= 5'd0;
         cmd_ff       <= CMD_IDLE;
         tick_ff      <= 8'd0;
         sub_ff       <= 2'd0;
         shift_out_ff <= 8'd0;
         shift_in_ff  <= 8'd0;
         ack_ff       <= 1'b1;
         drv_scl_ff   <= 1'b1;
         drv_sda_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            tpp_ff <= csr_wr_data;
         end
         phase_ff     <= phase_in;
         cmd_ff       <= cmd_in;
         tick_ff      <= tick_in;
         sub_ff       <= sub_in;
         shift_out_ff <= shift_out_in;
         shift_in_ff  <= shift_in_in;
         ack_ff       <= ack_in;
         drv_scl_ff   <= drv_scl_in;
         drv_sda_ff   <= drv_sda_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/i2c_master_bit_engine_core.sv -----
//  channel | dir | handshake              | payload
//  req     | in  | req_valid / req_stall  | req_data : op, tx_byte, sda_in
//  rsp     | out | rsp_valid / rsp_stall  | rsp_data : pins, status, rx_byte
//  csr     | in  | csr_wr_en              | csr_wr_data : ticks_per_phase
//
//  One beat in per clock while req_stall is low, one result beat out for each
//  beat in. A result passes through the queue and then the output register;
//  back to back beats stream at one per clock while neither stall is raised.
//  reset is synchronous: pins released high, ack store 1, no command running,
//  ticks_per_phase = 1, queue empty.
//  rsp_stall holds the output register; the two-entry queue absorbs beats and
//  req_stall rises only when the queue is full.
module i2c_master_bit_engine_core (
   input  logic               clock,
   input  logic               reset,
   // command / tick beats
   input  logic               req_valid,
   output logic               req_stall,
   input  i2cmb_pkg::req_type req_data,
   // result beats
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output i2cmb_pkg::rsp_type rsp_data,
   // ticks_per_phase register
   input  logic               csr_wr_en,
   input  logic [7:0]         csr_wr_data
);
   import i2cmb_pkg::*;

   // front -> queue
   logic     push;
   logic     q_full;
   item_type push_item;

   // queue -> back
   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   // Front: accept the beat and tag it as tick, command or unknown op.
   i2cmb_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (push),
      .q_item    (push_item)
   );

   // Short queue decoupling accept from execution.
   i2cmb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_item  (q_item)
   );

   // Back: phase sequencer, pin drivers, shifters, output register.
   i2cmb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

// ----- rtl/i2cmb_checker.sv -----
`include "i2c_master_bit_engine_core_defines.svh"

module i2cmb_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input i2cmb_pkg::rsp_type rsp_data
);
   import i2cmb_pkg::*;

   // a stalled result holds
   `I2CMB_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // finishing a sequence leaves the engine idle
   `I2CMB_ASSERT_IMP(a_done_idle, rsp_valid && rsp_data.done_res, !rsp_data.busy_res)

   // a reject only happens while a sequence runs, and it keeps running
   `I2CMB_ASSERT_IMP(a_rej_busy, rsp_valid && rsp_data.rejected, rsp_data.busy_res)

   // no result right after reset
   `I2CMB_ASSERT_NEXT_RST(a_rst_empty, reset, !rsp_valid)

endmodule

bind i2c_master_bit_engine_core i2cmb_checker u_checker (.*);
